// File: sv/ffra_pkg.sv
`timescale 1ns / 1ps

package ffra_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int ADDR_BITS     = 32;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int CMP_BITS      = (ADDR_BITS > 32) ? ADDR_BITS : 32;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [IDX_BITS-1:0]  idx_t;

	// entry type codes
	localparam logic [2:0] TYPE_UNUSED = 3'd0;
	localparam logic [2:0] TYPE_FREE   = 3'd1;

	typedef enum logic [1:0] {
		KIND_FORMAT = 2'd0,
		KIND_SIZE   = 2'd1,
		KIND_REGION = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

	// one range descriptor as held in the table memory
	typedef struct packed {
		logic [2:0] etype;
		addr_t      start_addr;
		addr_t      end_addr;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef struct packed {
		status_t code;
		idx_t    index;
		entry_t  entry;
	} result_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FORMAT,
		OP_ERROR,
		OP_READ_ISSUE,
		OP_READ_DONE,
		OP_SCAN_CLEAR,
		OP_SCAN_STEP,
		OP_DECIDE,
		OP_WRITE_FREE,
		OP_WRITE_SPLIT,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		kind_t   kind;
		logic    bad;
		logic    scan_last;
		status_t verdict;
		logic    split;
	} stat_t;

endpackage

// File: sv/first_fit_range_allocator_unit.sv
`timescale 1ns / 1ps

// First-fit range allocator over a table of TABLE_ENTRIES range descriptors
// (type, inclusive start and end address) held in a single-port-write,
// registered-read memory. Format, read and bad requests do not walk the
// table; allocate by size and allocate region walk the whole table one entry
// per cycle through the memory read port and then write up to three entries
// through its single write port; a failed allocation writes none, and only a
// split writes the third entry. One request is worked on at a time; its
// result waits in an output register and the next request is taken once that
// result has been staged. After reset every entry reads as unused with zero
// addresses; no clearing pass is needed.

module first_fit_range_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] alloc_size,
	input  logic [31:0] region_start,
	input  logic [31:0] region_end,
	input  logic [2:0]  file_type,
	input  logic [3:0]  entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  result_index,
	output logic [31:0] result_start,
	output logic [31:0] result_end,
	output logic [2:0]  result_type
);

	import ffra_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, scan and result datapath
	ffra_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.alloc_size  (alloc_size),
		.region_start(region_start),
		.region_end  (region_end),
		.file_type   (file_type),
		.entry_index (entry_index),
		.status      (status),
		.result_index(result_index),
		.result_start(result_start),
		.result_end  (result_end),
		.result_type (result_type)
	);

endmodule

// File: sv/ffra_ram.sv
`timescale 1ns / 1ps

module ffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/ffra_datapath.sv
`timescale 1ns / 1ps

module ffra_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  ffra_pkg::cmd_t cmd,
	output ffra_pkg::stat_t stat,
	input  logic [1:0]     kind,
	input  logic [31:0]    alloc_size,
	input  logic [31:0]    region_start,
	input  logic [31:0]    region_end,
	input  logic [2:0]     file_type,
	input  logic [3:0]     entry_index,
	output logic [1:0]     status,
	output logic [3:0]     result_index,
	output logic [31:0]    result_start,
	output logic [31:0]    result_end,
	output logic [2:0]     result_type
);

	import ffra_pkg::*;

	// request registers
	kind_t      kind_q;
	logic [31:0] size_m1_q;
	logic       size_zero_q;
	addr_t      rs_q;
	addr_t      re_q;
	logic [2:0] ftype_q;
	logic [3:0] idx_q;

	// scan state
	idx_t   scan_q;
	logic   rd_vld_s1;
	logic   rd_live_s1;
	idx_t   rd_idx_s1;
	logic   found_q;
	idx_t   fr_idx_q;
	addr_t  fr_start_q;
	addr_t  fr_end_q;
	logic   nu_found_q;
	idx_t   nu_q;
	logic   sp_found_q;
	idx_t   sp_q;

	logic [TABLE_ENTRIES-1:0] valid_q;

	result_t res_q;
	result_t out_q;

	// memory port signals
	logic                  ram_we;
	idx_t                  ram_waddr;
	entry_t                ram_wdata;
	idx_t                  ram_raddr;
	logic [ENTRY_BITS-1:0] ram_rdata;
	entry_t                rd_entry;

	// derived values
	addr_t   size_end;
	addr_t   span;
	logic    match;
	logic    split;
	status_t verdict;
	entry_t  new_entry;
	entry_t  fr_entry;
	entry_t  sp_entry;
	logic    bad;

	// capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			kind_q      <= kind_t'(kind);
			size_m1_q   <= alloc_size - 32'd1;
			size_zero_q <= (alloc_size == 32'd0);
			rs_q        <= ADDR_BITS'(region_start);
			re_q        <= ADDR_BITS'(region_end);
			ftype_q     <= file_type;
			idx_q       <= entry_index;
		end
	end

	// request sanity
	always_comb begin
		unique case (kind_q)
			KIND_FORMAT: bad = (re_q < rs_q);
			KIND_READ:   bad = (int'(idx_q) >= TABLE_ENTRIES);
			KIND_SIZE:   bad = (ftype_q < 3'd2) || size_zero_q;
			KIND_REGION: bad = (ftype_q < 3'd2) || (re_q < rs_q);
			default:     bad = 1'b1;
		endcase
	end

	// table memory, entries never written read as zero
	ffra_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_raddr = (cmd.op == OP_READ_ISSUE) ? IDX_BITS'(idx_q) : scan_q;
	assign rd_entry  = rd_live_s1 ? entry_t'(ram_rdata) : '0;

	// per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.op == OP_FORMAT) begin
			valid_q <= TABLE_ENTRIES'(1);
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// read pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= (cmd.op == OP_SCAN_STEP);
			rd_live_s1 <= valid_q[ram_raddr];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
	end

	// candidate test for the entry coming back from the memory
	assign span = rd_entry.end_addr - rd_entry.start_addr;

	always_comb begin
		if (kind_q == KIND_SIZE) begin
			match = (rd_entry.etype == TYPE_FREE) &&
				(rd_entry.end_addr >= rd_entry.start_addr) &&
				(CMP_BITS'(span) >= CMP_BITS'(size_m1_q));
		end else begin
			match = (rd_entry.etype == TYPE_FREE) &&
				(rd_entry.start_addr <= rs_q) && (rd_entry.end_addr >= re_q);
		end
	end

	// scan over the table: first fit plus first two unused entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			found_q    <= 1'b0;
			nu_found_q <= 1'b0;
			sp_found_q <= 1'b0;
		end else if (cmd.op == OP_SCAN_CLEAR) begin
			scan_q     <= '0;
			found_q    <= 1'b0;
			nu_found_q <= 1'b0;
			sp_found_q <= 1'b0;
		end else begin
			if (cmd.op == OP_SCAN_STEP) begin
				scan_q <= scan_q + idx_t'(1);
			end
			if (rd_vld_s1) begin
				if (match && !found_q) begin
					found_q <= 1'b1;
				end
				if (rd_entry.etype == TYPE_UNUSED) begin
					if (!nu_found_q) begin
						nu_found_q <= 1'b1;
					end else if (!sp_found_q) begin
						sp_found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (match && !found_q) begin
				fr_idx_q   <= rd_idx_s1;
				fr_start_q <= rd_entry.start_addr;
				fr_end_q   <= rd_entry.end_addr;
			end
			if (rd_entry.etype == TYPE_UNUSED) begin
				if (!nu_found_q) begin
					nu_q <= rd_idx_s1;
				end else if (!sp_found_q) begin
					sp_q <= rd_idx_s1;
				end
			end
		end
	end

	// allocation outcome
	assign size_end = fr_start_q + ADDR_BITS'(size_m1_q);
	assign split    = (kind_q == KIND_REGION) && (fr_start_q != rs_q) && (fr_end_q != re_q);

	always_comb begin
		priority if (!found_q) begin
			verdict = ST_NOSPACE;
		end else if (!nu_found_q) begin
			verdict = ST_FULL;
		end else if (split && !sp_found_q) begin
			verdict = ST_FULL;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		sp_entry = '{etype: TYPE_FREE, start_addr: re_q + addr_t'(1), end_addr: fr_end_q};
		if (kind_q == KIND_SIZE) begin
			new_entry = '{etype: ftype_q, start_addr: fr_start_q, end_addr: size_end};
			if (size_end == fr_end_q) begin
				fr_entry = '{etype: TYPE_UNUSED, start_addr: fr_start_q, end_addr: fr_end_q};
			end else begin
				fr_entry = '{etype: TYPE_FREE, start_addr: size_end + addr_t'(1),
					end_addr: fr_end_q};
			end
		end else begin
			new_entry = '{etype: ftype_q, start_addr: rs_q, end_addr: re_q};
			// front trim moves start, back trim and split move end
			fr_entry.etype = ((fr_start_q == rs_q) && (fr_end_q == re_q)) ?
				TYPE_UNUSED : TYPE_FREE;
			fr_entry.start_addr = ((fr_start_q == rs_q) && (fr_end_q != re_q)) ?
				re_q + addr_t'(1) : fr_start_q;
			fr_entry.end_addr = (fr_start_q != rs_q) ? rs_q - addr_t'(1) : fr_end_q;
		end
	end

	// memory write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (cmd.op)
			OP_FORMAT: begin
				ram_we    = 1'b1;
				ram_wdata = '{etype: TYPE_FREE, start_addr: rs_q, end_addr: re_q};
			end
			OP_DECIDE: begin
				ram_we    = (verdict == ST_OK);
				ram_waddr = nu_q;
				ram_wdata = new_entry;
			end
			OP_WRITE_FREE: begin
				ram_we    = 1'b1;
				ram_waddr = fr_idx_q;
				ram_wdata = fr_entry;
			end
			OP_WRITE_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = sp_q;
				ram_wdata = sp_entry;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// staged result
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_FORMAT: begin
				res_q <= '{code: ST_OK, index: '0,
					entry: '{etype: TYPE_FREE, start_addr: rs_q, end_addr: re_q}};
			end
			OP_ERROR: begin
				res_q <= '{code: ST_BAD, index: '0, entry: '0};
			end
			OP_READ_DONE: begin
				res_q <= '{code: ST_OK, index: IDX_BITS'(idx_q), entry: rd_entry};
			end
			OP_DECIDE: begin
				if (verdict == ST_OK) begin
					res_q <= '{code: ST_OK, index: nu_q, entry: new_entry};
				end else begin
					res_q <= '{code: verdict, index: '0, entry: '0};
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// output register, held while the result beat is stalled
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			out_q <= res_q;
		end
	end

	assign status       = out_q.code;
	assign result_index = 4'(out_q.index);
	assign result_start = 32'(out_q.entry.start_addr);
	assign result_end   = 32'(out_q.entry.end_addr);
	assign result_type  = out_q.entry.etype;

	// status towards the controller
	assign stat.kind      = kind_q;
	assign stat.bad       = bad;
	assign stat.scan_last = (scan_q == idx_t'(TABLE_ENTRIES - 1));
	assign stat.verdict   = verdict;
	assign stat.split     = split;

endmodule

// File: sv/ffra_ctrl.sv
`timescale 1ns / 1ps

module ffra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  ffra_pkg::stat_t stat,
	output ffra_pkg::cmd_t  cmd
);

	import ffra_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_FREE,
		S_SPLIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   publish;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign publish   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// datapath operation for the current state
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_CHECK: begin
				if (stat.bad) begin
					cmd.op = OP_ERROR;
				end else begin
					unique case (stat.kind)
						KIND_FORMAT: cmd.op = OP_FORMAT;
						KIND_READ:   cmd.op = OP_READ_ISSUE;
						default:     cmd.op = OP_SCAN_CLEAR;
					endcase
				end
			end
			S_READ:   cmd.op = OP_READ_DONE;
			S_SCAN:   cmd.op = OP_SCAN_STEP;
			S_DRAIN:  cmd.op = OP_NONE;
			S_DECIDE: cmd.op = OP_DECIDE;
			S_FREE:   cmd.op = OP_WRITE_FREE;
			S_SPLIT:  cmd.op = OP_WRITE_SPLIT;
			S_DONE: begin
				if (publish) begin
					cmd.op = OP_PUBLISH;
				end
			end
			default:  cmd.op = OP_NONE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.bad) begin
						state_q <= S_DONE;
					end else begin
						unique case (stat.kind)
							KIND_FORMAT: state_q <= S_DONE;
							KIND_READ:   state_q <= S_READ;
							default:     state_q <= S_SCAN;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= (stat.verdict == ST_OK) ? S_FREE : S_DONE;
				end
				S_FREE: begin
					state_q <= stat.split ? S_SPLIT : S_DONE;
				end
				S_SPLIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (publish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: verif/first_fit_range_allocator_unit_tb.sv
`timescale 1ns / 1ps

module first_fit_range_allocator_unit_tb;
	import ffra_pkg::*;

	localparam int    RANDOM_ITEMS = 500;
	localparam int    QUIET_LIMIT  = 2000;
	localparam int    DRAIN_CYCLES = 60;
	localparam int    NUM_DIRECTED = 24;
	localparam addr_t TOP          = 32'hFFFF_FFFF;

	// one request beat as driven on the input channel
	typedef struct packed {
		kind_t      kind;
		addr_t      size;
		addr_t      lo;
		addr_t      hi;
		logic [2:0] ftype;
		idx_t       idx;
	} request_t;

	typedef struct packed {
		request_t   req;
		logic [4:0] reps;
		logic       typed;
		result_t    want;
	} directed_row_t;

	localparam result_t WANT_NONE    = '0;
	localparam result_t WANT_BAD     = '{ST_BAD, '0, '0};
	localparam result_t WANT_NOSPACE = '{ST_NOSPACE, '0, '0};
	localparam result_t WANT_FULL    = '{ST_FULL, '0, '0};

	// directed stimulus: typed answers only where they are obvious
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		// reads straight after reset
		'{'{KIND_READ, 32'd0, 32'd0, 32'd0, 3'd0, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd0, '{TYPE_UNUSED, 32'd0, 32'd0}}},
		'{'{KIND_READ, 32'd0, 32'd0, 32'd0, 3'd0, 4'd15}, 5'd1, 1'b1,
			'{ST_OK, 4'd15, '{TYPE_UNUSED, 32'd0, 32'd0}}},
		// nothing free yet
		'{'{KIND_SIZE, 32'd1, 32'd0, 32'd0, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_NOSPACE},
		// format with end below start
		'{'{KIND_FORMAT, 32'd0, 32'd10, 32'd5, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_BAD},
		'{'{KIND_FORMAT, 32'd0, 32'd0, TOP, 3'd2, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd0, '{TYPE_FREE, 32'd0, TOP}}},
		// bad requests: zero size, reserved type codes, reversed region
		'{'{KIND_SIZE, 32'd0, 32'd0, 32'd0, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_BAD},
		'{'{KIND_SIZE, 32'd16, 32'd0, 32'd0, 3'd0, 4'd0}, 5'd1, 1'b1, WANT_BAD},
		'{'{KIND_REGION, 32'd0, 32'd0, 32'd15, 3'd1, 4'd0}, 5'd1, 1'b1, WANT_BAD},
		'{'{KIND_REGION, 32'd0, 32'h2000, 32'h1FFF, 3'd3, 4'd0}, 5'd1, 1'b1, WANT_BAD},
		// carve from the front, split, front trim, back trim at the top
		'{'{KIND_SIZE, 32'h100, 32'd0, 32'd0, 3'd7, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_REGION, 32'd0, 32'h1000, 32'h1FFF, 3'd3, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_REGION, 32'd0, 32'h100, 32'h1FF, 3'd4, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_REGION, 32'd0, 32'hFFFF_0000, TOP, 3'd5, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_REGION, 32'd0, 32'h150, 32'h160, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_NOSPACE},
		// takes a whole free range, which then goes back to unused
		'{'{KIND_SIZE, 32'hE00, 32'd0, 32'd0, 3'd6, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_SIZE, TOP, 32'd0, 32'd0, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_NOSPACE},
		'{'{KIND_FORMAT, 32'd0, TOP, TOP, 3'd2, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd0, '{TYPE_FREE, TOP, TOP}}},
		'{'{KIND_SIZE, 32'd1, 32'd0, 32'd0, 3'd7, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		// fill the table, then a split with no spare entry and a full table
		'{'{KIND_FORMAT, 32'd0, 32'd0, 32'h3FF, 3'd2, 4'd0}, 5'd1, 1'b1,
			'{ST_OK, 4'd0, '{TYPE_FREE, 32'd0, 32'h3FF}}},
		'{'{KIND_SIZE, 32'd1, 32'd0, 32'd0, 3'd2, 4'd0}, 5'd14, 1'b0, WANT_NONE},
		'{'{KIND_REGION, 32'd0, 32'h100, 32'h100, 3'd3, 4'd0}, 5'd1, 1'b1, WANT_FULL},
		'{'{KIND_REGION, 32'd0, 32'hE, 32'hE, 3'd4, 4'd0}, 5'd1, 1'b0, WANT_NONE},
		'{'{KIND_SIZE, 32'd1, 32'd0, 32'd0, 3'd2, 4'd0}, 5'd1, 1'b1, WANT_FULL},
		'{'{KIND_READ, 32'd0, 32'd0, 32'd0, 3'd0, 4'd15}, 5'd1, 1'b0, WANT_NONE}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] alloc_size;
	logic [31:0] region_start;
	logic [31:0] region_end;
	logic [2:0]  file_type;
	logic [3:0]  entry_index;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [3:0]  result_index;
	logic [31:0] result_start;
	logic [31:0] result_end;
	logic [2:0]  result_type;

	// own copy of the range table
	logic [2:0] tbl_type  [TABLE_ENTRIES];
	addr_t      tbl_start [TABLE_ENTRIES];
	addr_t      tbl_end   [TABLE_ENTRIES];

	result_t answers_due [$];
	int      mismatch_count;
	int      answers_seen;
	int      quiet_cycles;
	int      send_idle_pct;
	int      recv_stall_pct;

	first_fit_range_allocator_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_type[i]  = TYPE_UNUSED;
			tbl_start[i] = '0;
			tbl_end[i]   = '0;
		end
	endfunction

	function automatic int first_unused_after(int after);
		for (int i = after + 1; i < TABLE_ENTRIES; i++)
			if (tbl_type[i] == TYPE_UNUSED)
				return i;
		return -1;
	endfunction

	function automatic result_t entry_answer(int i);
		result_t res;
		res.code  = ST_OK;
		res.index = idx_t'(i);
		res.entry = '{tbl_type[i], tbl_start[i], tbl_end[i]};
		return res;
	endfunction

	// updates the table for one request and returns its answer
	function automatic result_t apply_request(request_t r);
		result_t res;
		int      fr;
		int      nu;
		int      sp;
		logic    fits;
		fr       = -1;
		res      = '0;
		res.code = ST_BAD;
		case (r.kind)
			KIND_FORMAT: begin
				if (r.hi >= r.lo) begin
					clear_table();
					tbl_type[0]  = TYPE_FREE;
					tbl_start[0] = r.lo;
					tbl_end[0]   = r.hi;
					res = entry_answer(0);
				end
			end
			KIND_READ: res = entry_answer(int'(r.idx));
			default: begin
				if (r.ftype < 3'd2 || (r.kind == KIND_SIZE && r.size == '0) ||
						(r.kind == KIND_REGION && r.hi < r.lo))
					return res;
				// first fit search
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (r.kind == KIND_SIZE)
						fits = tbl_end[i] >= tbl_start[i] &&
							tbl_end[i] - tbl_start[i] >= r.size - 32'd1;
					else
						fits = tbl_start[i] <= r.lo && tbl_end[i] >= r.hi;
					if (fr < 0 && tbl_type[i] == TYPE_FREE && fits)
						fr = i;
				end
				res.code = ST_NOSPACE;
				if (fr < 0)
					return res;
				res.code = ST_FULL;
				nu = first_unused_after(-1);
				if (nu < 0)
					return res;
				if (r.kind == KIND_SIZE) begin
					tbl_type[nu]  = r.ftype;
					tbl_start[nu] = tbl_start[fr];
					tbl_end[nu]   = tbl_start[fr] + r.size - 32'd1;
					if (tbl_end[nu] == tbl_end[fr])
						tbl_type[fr] = TYPE_UNUSED;
					else
						tbl_start[fr] = tbl_end[nu] + 32'd1;
				end else begin
					sp = -1;
					if (tbl_start[fr] != r.lo && tbl_end[fr] != r.hi) begin
						sp = first_unused_after(nu);
						if (sp < 0)
							return res;
					end
					if (tbl_start[fr] == r.lo) begin
						if (tbl_end[fr] == r.hi)
							tbl_type[fr] = TYPE_UNUSED;
						else
							tbl_start[fr] = r.hi + 32'd1;
					end else if (tbl_end[fr] == r.hi) begin
						tbl_end[fr] = r.lo - 32'd1;
					end else begin
						tbl_type[sp]  = TYPE_FREE;
						tbl_start[sp] = r.hi + 32'd1;
						tbl_end[sp]   = tbl_end[fr];
						tbl_end[fr]   = r.lo - 32'd1;
					end
					tbl_type[nu]  = r.ftype;
					tbl_start[nu] = r.lo;
					tbl_end[nu]   = r.hi;
				end
				res = entry_answer(nu);
			end
		endcase
		return res;
	endfunction

	function automatic addr_t pick_between(addr_t lo, addr_t hi);
		logic [63:0] rnd;
		logic [63:0] width;
		rnd   = {$urandom, $urandom};
		width = {32'd0, hi} - {32'd0, lo} + 64'd1;
		return lo + addr_t'(rnd % width);
	endfunction

	// mostly well-formed requests aimed at the current free ranges
	function automatic request_t random_request();
		request_t r;
		int       free_list [$];
		int       choice;
		int       pick;
		int       f;
		addr_t    s;
		addr_t    e;
		addr_t    span;
		r.kind  = kind_t'($urandom_range(3, 0));
		r.size  = $urandom;
		r.lo    = $urandom;
		r.hi    = $urandom;
		r.ftype = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(1, 0)) :
			3'($urandom_range(7, 2));
		r.idx   = idx_t'($urandom_range(15, 0));
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_type[i] == TYPE_FREE)
				free_list.push_back(i);
		choice = $urandom_range(99, 0);
		pick   = $urandom_range(99, 0);

		// format: half of them small ranges so the table fills up
		if (choice < 3 || (free_list.size() == 0 && choice < 60)) begin
			r.kind = KIND_FORMAT;
			if (pick < 50) begin
				r.hi = r.lo + 32'($urandom_range(255, 0));
				if (r.hi < r.lo)
					r.hi = TOP;
			end else if (pick < 75) begin
				if (r.hi < r.lo)
					{r.lo, r.hi} = {r.hi, r.lo};
			end else if (pick < 88) begin
				r.lo = 32'($urandom_range(15, 0));
				r.hi = TOP - 32'($urandom_range(15, 0));
			end
			return r;
		end
		// reads, or noise when nothing is free
		if (choice >= 80 || free_list.size() == 0) begin
			if (choice >= 80)
				r.kind = KIND_READ;
			return r;
		end

		f    = free_list[$urandom_range(free_list.size() - 1, 0)];
		s    = tbl_start[f];
		e    = tbl_end[f];
		span = e - s;
		if (choice < 45) begin
			r.kind = KIND_SIZE;
			if (pick < 35)
				r.size = pick_between('0, span) + 32'd1;
			else if (pick < 55)
				r.size = span + 32'd1;
			else if (pick < 75)
				r.size = 32'($urandom_range(16, 1));
			else if (pick < 85)
				r.size = span + 32'd2;
			else if (pick < 92)
				r.size = '0;
		end else begin
			r.kind = KIND_REGION;
			if (pick < 20) begin
				r.lo = s;
				r.hi = e;
			end else if (pick < 40) begin
				r.lo = s;
				r.hi = pick_between(s, e);
			end else if (pick < 60) begin
				r.hi = e;
				r.lo = pick_between(s, e);
			end else if (pick < 85) begin
				r.lo = pick_between(s, e);
				r.hi = pick_between(r.lo, e);
			end else if (pick < 92) begin
				if (r.hi < r.lo)
					{r.lo, r.hi} = {r.hi, r.lo};
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("answer %0d: %s is %h, expected %h",
				answers_seen, name, got, want));
	endtask

	task automatic compare_answer(input result_t want);
		check_field("status", 32'(status), 32'(want.code));
		check_field("index", 32'(result_index), 32'(want.index));
		check_field("start", result_start, want.entry.start_addr);
		check_field("end", result_end, want.entry.end_addr);
		check_field("type", 32'(result_type), 32'(want.entry.etype));
		answers_seen++;
	endtask

	// drive one request beat, hold it until taken, then update the table copy
	task automatic send_request(input request_t r, input logic typed, input result_t want);
		result_t predicted;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= r.kind;
		alloc_size   <= r.size;
		region_start <= r.lo;
		region_end   <= r.hi;
		file_type    <= r.ftype;
		entry_index  <= r.idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_request(r);
		answers_due.push_back(typed ? want : predicted);
	endtask

	// answer side: stall at random, check each beat taken, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0)
					report_mismatch($sformatf("answer with no request waiting, status %0d",
						status));
				else
					compare_answer(answers_due.pop_front());
			end
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		kind           <= '0;
		alloc_size     <= '0;
		region_start   <= '0;
		region_end     <= '0;
		file_type      <= '0;
		entry_index    <= '0;
		out_stall      <= 1'b0;
		mismatch_count = 0;
		answers_seen   = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		clear_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			for (int k = 0; k < int'(DIRECTED[i].reps); k++)
				send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

		// random part, cycling through the idling phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase = (n / 50) % 4;
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			send_request(random_request(), 1'b0, WANT_NONE);
		end
		in_valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
